[hdl/wtd_pkg.sv]
// ============================================================================
// wtd_pkg: shared types and constants of the waypoint tracking drive
// Request structs, configuration struct, command and event codes, CORDIC
// angle table.
// ============================================================================
package wtd_pkg;

  // Input request as seen on the push side.
  typedef struct packed {
    logic [1:0]         command;
    logic               new_path;
    logic signed [23:0] coord_x;
    logic signed [23:0] coord_y;
    logic signed [15:0] heading;
  } wtd_in_t;

  // Result request as seen on the pop side.
  typedef struct packed {
    logic signed [15:0] left_drive;
    logic signed [15:0] right_drive;
    logic               tracking;
    logic [2:0]         event_res;
    logic [7:0]         target_index;
  } wtd_out_t;

  // Classified request handed from the front end to the executor.
  typedef struct packed {
    logic [1:0]         kind;
    logic               new_path;
    logic signed [23:0] coord_x;
    logic signed [23:0] coord_y;
    logic signed [15:0] heading;
  } wtd_job_t;

  // Configuration register set.
  typedef struct packed {
    logic [22:0] goal_tol;
    logic [22:0] lookahead;
    logic [15:0] speed_gain;
    logic [15:0] turn_gain;
    logic [14:0] drive_limit;
  } wtd_cfg_t;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_POSE  = 2'd2;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_POSE  = 2'd2;
  localparam logic [1:0] KIND_NOP   = 2'd3;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_DRIVE   = 3'd1;
  localparam logic [2:0] EV_ADVANCE = 3'd2;
  localparam logic [2:0] EV_GOAL    = 3'd3;
  localparam logic [2:0] EV_NO_PATH = 3'd4;

  localparam logic [2:0] REG_GOAL_TOL  = 3'd0;
  localparam logic [2:0] REG_LOOKAHEAD = 3'd1;
  localparam logic [2:0] REG_SPEED     = 3'd2;
  localparam logic [2:0] REG_TURN      = 3'd3;
  localparam logic [2:0] REG_LIMIT     = 3'd4;

  localparam logic signed [19:0] PI_Q16   = 20'sd205887;
  localparam logic [15:0]        KINV_Q16 = 16'd39797;

  // Arctangent of 2^-i in Q.16, rounded.
  function automatic logic signed [19:0] wtd_atan(input logic [4:0] i);
    logic signed [19:0] v;
    case (i)
      5'd0:    v = 20'sd51472;
      5'd1:    v = 20'sd30386;
      5'd2:    v = 20'sd16055;
      5'd3:    v = 20'sd8150;
      5'd4:    v = 20'sd4091;
      5'd5:    v = 20'sd2047;
      5'd6:    v = 20'sd1024;
      5'd7:    v = 20'sd512;
      5'd8:    v = 20'sd256;
      5'd9:    v = 20'sd128;
      5'd10:   v = 20'sd64;
      5'd11:   v = 20'sd32;
      5'd12:   v = 20'sd16;
      5'd13:   v = 20'sd8;
      5'd14:   v = 20'sd4;
      5'd15:   v = 20'sd2;
      5'd16:   v = 20'sd1;
      default: v = 20'sd0;
    endcase
    return v;
  endfunction

endpackage

[hdl/waypoint_tracking_drive_top.sv]
// ============================================================================
// waypoint_tracking_drive_top: pure pursuit waypoint tracking drive
// Path store, CORDIC vectoring and wheel drive law behind queue ports.
// ============================================================================
// Requests enter on in_push/in_full; each one yields exactly one result on
// out_empty/out_pop, in order. Commands: load waypoint, start tracking,
// pose step. Configuration is written through cfg_we/cfg_index/cfg_data;
// the user must write it only while the block is idle, which the block itself does not enforce.
// A front queue of two requests decouples intake from the executor, and a
// one-entry result register decouples the executor from the receiver.
// Load, start and idle pose requests go from the idle state straight to the
// done state. A tracking pose step reads the target and then the last
// waypoint through the one path memory read port, sets up the vector and
// runs the single CORDIC rotation unit, one iteration per cycle, then forms
// distance and bearing error and decides; a step that updates the drives
// takes one more decision pass to saturate them.
// Reset empties both queues, clears the path, tracking and held drives, and
// loads register defaults. The path memory itself is not cleared.
// When the receiver stalls, the result register holds, the executor waits
// with its result, and the front queue keeps accepting until full.
// ============================================================================
module waypoint_tracking_drive_top
  import wtd_pkg::*;
#(
  parameter int PATH_DEPTH   = 256,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  wtd_in_t     in_item,
  output logic        out_empty,
  input  logic        out_pop,
  output wtd_out_t    out_item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [22:0] cfg_data
);

  wtd_cfg_t cfg_r;
  wtd_job_t job;
  wtd_out_t res;
  wtd_out_t out_r;
  logic     job_valid, job_take, res_valid, res_ready, out_valid_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.goal_tol    <= 23'd205;
      cfg_r.lookahead   <= 23'd819;
      cfg_r.speed_gain  <= 16'd256;
      cfg_r.turn_gain   <= 16'd256;
      cfg_r.drive_limit <= 15'd32767;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GOAL_TOL:  cfg_r.goal_tol    <= cfg_data;
        REG_LOOKAHEAD: cfg_r.lookahead   <= cfg_data;
        REG_SPEED:     cfg_r.speed_gain  <= cfg_data[15:0];
        REG_TURN:      cfg_r.turn_gain   <= cfg_data[15:0];
        REG_LIMIT:     cfg_r.drive_limit <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  wtd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .full      (in_full),
    .item      (in_item),
    .job_valid (job_valid),
    .job_take  (job_take),
    .job       (job)
  );

  wtd_exec #(
    .PATH_DEPTH   (PATH_DEPTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_valid (job_valid),
    .job_take  (job_take),
    .job       (job),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Result register.
  assign res_ready = !out_valid_r || out_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_r;

endmodule

[hdl/wtd_front.sv]
// ============================================================================
// wtd_front: request intake and classification
// Decodes the command of each accepted request and holds up to two
// classified requests for the executor.
// ============================================================================
module wtd_front
  import wtd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  wtd_in_t  item,
  output logic     job_valid,
  input  logic     job_take,
  output wtd_job_t job
);

  wtd_job_t   q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  wtd_job_t   cls;
  logic       wr, rd;

  // Classify the command.
  always_comb begin
    cls.new_path = item.new_path;
    cls.coord_x  = item.coord_x;
    cls.coord_y  = item.coord_y;
    cls.heading  = item.heading;
    case (item.command)
      CMD_LOAD:  cls.kind = KIND_LOAD;
      CMD_START: cls.kind = KIND_START;
      CMD_POSE:  cls.kind = KIND_POSE;
      default:   cls.kind = KIND_NOP;
    endcase
  end

  assign full      = (cnt_r == 2'd2);
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rp_r];
  assign wr        = push && !full;
  assign rd        = job_take && job_valid;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wp_r] <= cls;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

[hdl/wtd_exec.sv]
// ============================================================================
// wtd_exec: path store and control step executor
// Holds the waypoint path, runs CORDIC vectoring and the drive law, and
// presents one result per request.
// ============================================================================
module wtd_exec
  import wtd_pkg::*;
#(
  parameter int PATH_DEPTH   = 256,
  parameter int CORDIC_STEPS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  wtd_cfg_t cfg,
  input  logic     job_valid,
  output logic     job_take,
  input  wtd_job_t job,
  output logic     res_valid,
  input  logic     res_ready,
  output wtd_out_t res
);

  localparam int AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
  localparam int PW = (AW > 8) ? AW : 8;
  localparam int CW = $clog2(CORDIC_STEPS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDT  = 3'd1;
  localparam logic [2:0] S_RDL  = 3'd2;
  localparam logic [2:0] S_INIT = 3'd3;
  localparam logic [2:0] S_ROT  = 3'd4;
  localparam logic [2:0] S_DIST = 3'd5;
  localparam logic [2:0] S_DEC  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]          st_r;
  logic                clamp_r;
  logic [47:0]         mem [PATH_DEPTH];
  logic [47:0]         rdata_r;
  logic [AW-1:0]       raddr;
  logic                mwe;
  logic [AW:0]         len_r;
  logic [AW-1:0]       tgt_r, lst;
  logic                loaded_r, track_r;
  logic signed [15:0]  left_r, right_r;
  logic [2:0]          ev_r;
  wtd_job_t            cur_r;
  logic signed [23:0]  tx_r, ty_r;
  logic                goal_r;
  logic signed [27:0]  x_r, y_r;
  logic signed [19:0]  z_r;
  logic [CW-1:0]       cnt_r;
  logic [26:0]         dist_r;
  logic signed [17:0]  err_r;
  logic signed [32:0]  a_r, b_r;
  logic signed [27:0]  dx, dy, xs, ys;
  logic [42:0]         dprod;
  logic signed [20:0]  zr;
  logic signed [16:0]  bear;
  logic [42:0]         aprod;
  logic signed [34:0]  bprod;
  logic signed [33:0]  lsum, rsum, lim;
  logic [PW-1:0]       tgt_ext;

  assign lst = (len_r != '0) ? AW'(len_r - 1'b1) : '0;

  // Path memory: one write and one registered read port.
  assign mwe   = (st_r == S_IDLE) && job_valid && (job.kind == KIND_LOAD) &&
                 (job.new_path || (len_r < (AW+1)'(PATH_DEPTH)));
  assign raddr = (st_r == S_RDT) ? tgt_r : lst;

  always_ff @(posedge clk) begin
    if (mwe) begin
      mem[job.new_path ? '0 : len_r[AW-1:0]] <= {job.coord_x, job.coord_y};
    end
    rdata_r <= mem[raddr];
  end

  assign job_take  = (st_r == S_IDLE);
  assign res_valid = (st_r == S_DONE);

  // Combinational helpers of the arithmetic steps.
  assign dx    = 28'(tx_r) - 28'(cur_r.coord_x);
  assign dy    = 28'(ty_r) - 28'(cur_r.coord_y);
  assign xs    = x_r >>> cnt_r;
  assign ys    = y_r >>> cnt_r;
  assign dprod = 43'(x_r[26:0]) * 43'(KINV_Q16) + 43'd32768;
  assign zr    = 21'(z_r) + 21'sd8;
  assign bear  = 17'(zr >>> 4);
  assign aprod = 43'(cfg.speed_gain) * 43'(dist_r);
  assign bprod = $signed({19'd0, cfg.turn_gain}) * 35'(err_r);
  assign lsum  = 34'(a_r) - 34'(b_r);
  assign rsum  = 34'(a_r) + 34'(b_r);
  assign lim   = $signed({19'd0, cfg.drive_limit});

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      len_r    <= '0;
      tgt_r    <= '0;
      loaded_r <= 1'b0;
      track_r  <= 1'b0;
      left_r   <= '0;
      right_r  <= '0;
      ev_r     <= EV_NONE;
      clamp_r  <= 1'b0;
      cnt_r    <= '0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (job_valid) begin
            cur_r <= job;
            ev_r  <= EV_NONE;
            st_r  <= S_DONE;
            case (job.kind)
              KIND_LOAD: begin
                if (job.new_path) begin
                  len_r    <= (AW+1)'(1);
                  tgt_r    <= '0;
                  loaded_r <= 1'b1;
                end else if (len_r < (AW+1)'(PATH_DEPTH)) begin
                  len_r    <= len_r + 1'b1;
                  loaded_r <= 1'b1;
                end
              end
              KIND_START: begin
                if (!loaded_r) ev_r <= EV_NO_PATH;
                else track_r <= 1'b1;
              end
              KIND_POSE: begin
                if (loaded_r && track_r) st_r <= S_RDT;
              end
              default: ;
            endcase
          end
        end
        S_RDT: st_r <= S_RDL;
        S_RDL: begin
          tx_r <= rdata_r[47:24];
          ty_r <= rdata_r[23:0];
          st_r <= S_INIT;
        end
        S_INIT: begin
          goal_r <= (rdata_r == {tx_r, ty_r});
          cnt_r  <= '0;
          if (dx < 0) begin
            x_r <= -dx;
            y_r <= -dy;
            z_r <= (dy >= 0) ? PI_Q16 : -PI_Q16;
          end else begin
            x_r <= dx;
            y_r <= dy;
            z_r <= '0;
          end
          st_r <= S_ROT;
        end
        S_ROT: begin
          if (y_r >= 0) begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + wtd_atan(5'(cnt_r));
          end else begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - wtd_atan(5'(cnt_r));
          end
          if (cnt_r == CW'(CORDIC_STEPS - 1)) st_r <= S_DIST;
          else cnt_r <= cnt_r + 1'b1;
        end
        S_DIST: begin
          dist_r  <= dprod[42:16];
          err_r   <= 18'(bear) - 18'(cur_r.heading);
          clamp_r <= 1'b0;
          st_r    <= S_DEC;
        end
        S_DEC: begin
          if (clamp_r) begin
            // Saturate the wheel drives.
            left_r  <= (lsum > lim) ? 16'(lim) : (lsum < -lim) ? 16'(-lim) : 16'(lsum);
            right_r <= (rsum > lim) ? 16'(lim) : (rsum < -lim) ? 16'(-lim) : 16'(rsum);
            ev_r    <= EV_DRIVE;
            st_r    <= S_DONE;
          end else if (goal_r && (dist_r < 27'(cfg.goal_tol))) begin
            left_r  <= '0;
            right_r <= '0;
            track_r <= 1'b0;
            ev_r    <= EV_GOAL;
            st_r    <= S_DONE;
          end else if (!goal_r && (dist_r < 27'(cfg.lookahead))) begin
            if ((AW+1)'(tgt_r) + 1'b1 < len_r) tgt_r <= tgt_r + 1'b1;
            ev_r <= EV_ADVANCE;
            st_r <= S_DONE;
          end else begin
            a_r     <= $signed({2'b00, aprod[42:12]});
            b_r     <= 33'(bprod >>> 12);
            clamp_r <= 1'b1;
          end
        end
        S_DONE: begin
          if (res_ready) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign tgt_ext          = PW'(tgt_r);
  assign res.left_drive   = left_r;
  assign res.right_drive  = right_r;
  assign res.tracking     = track_r;
  assign res.event_res    = ev_r;
  assign res.target_index = tgt_ext[7:0];

  // The path never exceeds the store.
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= (AW+1)'(PATH_DEPTH))
    else $error("path length beyond store depth");

  // The target always points inside a loaded path.
  a_tgt: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r |-> ((AW+1)'(tgt_r) < len_r))
    else $error("target pointer outside the path");

  // Tracking only runs on a loaded path.
  a_trk: assert property (@(posedge clk) disable iff (!rst_n)
    track_r |-> loaded_r)
    else $error("tracking without a path");

  // A result is held until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && $stable(ev_r)))
    else $error("result dropped before it was taken");

endmodule

[tb/wtd_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// wtd_checker: result checker for the waypoint tracking drive
// Watches the request, result and configuration ports, keeps its own model of
// the path store, tracking state and held drives, and compares every result
// request field by field against the oldest predicted result.
// ============================================================================
module wtd_checker
  import wtd_pkg::*;
#(
  parameter int PATH_DEPTH   = 256,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  wtd_in_t     in_item,
  input  logic        out_empty,
  input  logic        out_pop,
  input  wtd_out_t    out_item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [22:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  // Arctangent of 2^-i in Q.16.
  localparam longint ATAN_TAB [24] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                        256, 128, 64, 32, 16, 8, 4, 2, 1,
                                        0, 0, 0, 0, 0, 0, 0};

  // Mirrored block state.
  logic signed [23:0] wp_x [PATH_DEPTH];
  logic signed [23:0] wp_y [PATH_DEPTH];
  int                 path_len;
  int                 target_ptr;
  logic               have_path;
  logic               tracking_on;
  logic signed [15:0] left_hold;
  logic signed [15:0] right_hold;
  wtd_cfg_t           cfg;

  wtd_out_t           drive_results_q[$];

  function automatic longint limit_drive(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // One control step toward the current target; returns the event code.
  function automatic logic [2:0] control_step(longint rx, longint ry, longint hd);
    longint tx, ty, x, y, z, xn, reach, bearing, err, a, b;
    logic   at_goal;
    int     last;
    last    = path_len - 1;
    tx      = wp_x[target_ptr];
    ty      = wp_y[target_ptr];
    at_goal = (wp_x[target_ptr] == wp_x[last]) && (wp_y[target_ptr] == wp_y[last]);
    x = tx - rx;
    y = ty - ry;
    z = 0;
    // Fold the left half plane onto the right one before vectoring.
    if (x < 0) begin
      z = (y >= 0) ? longint'(PI_Q16) : -longint'(PI_Q16);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (y >= 0) begin
        xn = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ATAN_TAB[i];
      end else begin
        xn = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ATAN_TAB[i];
      end
      x = xn;
    end
    bearing = (z + 8) >>> 4;
    reach   = (x * longint'(KINV_Q16) + 32768) >>> 16;
    err     = bearing - hd;
    if (at_goal) begin
      if (reach < longint'(cfg.goal_tol)) begin
        left_hold   = '0;
        right_hold  = '0;
        tracking_on = 1'b0;
        return EV_GOAL;
      end
    end else if (reach < longint'(cfg.lookahead)) begin
      if (target_ptr + 1 < path_len) target_ptr++;
      return EV_ADVANCE;
    end
    a = (longint'(cfg.speed_gain) * reach) >>> 12;
    b = (longint'(cfg.turn_gain) * err) >>> 12;
    left_hold  = 16'(limit_drive(a - b, longint'(cfg.drive_limit)));
    right_hold = 16'(limit_drive(a + b, longint'(cfg.drive_limit)));
    return EV_DRIVE;
  endfunction

  // Applies one request to the mirrored state and returns its result.
  function automatic wtd_out_t predict_result(wtd_in_t rq);
    wtd_out_t   res;
    logic [2:0] ev;
    ev = EV_NONE;
    case (rq.command)
      CMD_LOAD: begin
        if (rq.new_path) begin
          path_len   = 0;
          target_ptr = 0;
        end
        if (path_len < PATH_DEPTH) begin
          wp_x[path_len] = rq.coord_x;
          wp_y[path_len] = rq.coord_y;
          path_len++;
          have_path = 1'b1;
        end
      end
      CMD_START: begin
        if (!have_path) ev = EV_NO_PATH;
        else tracking_on = 1'b1;
      end
      CMD_POSE: begin
        if (have_path && tracking_on)
          ev = control_step(rq.coord_x, rq.coord_y, rq.heading);
      end
      default: ;
    endcase
    res.left_drive   = left_hold;
    res.right_drive  = right_hold;
    res.tracking     = tracking_on;
    res.event_res    = ev;
    res.target_index = 8'(target_ptr);
    return res;
  endfunction

  // Track configuration, check results, then predict new requests.
  always @(posedge clk) begin
    wtd_out_t want;
    if (!rst_n) begin
      path_len    = 0;
      target_ptr  = 0;
      have_path   = 1'b0;
      tracking_on = 1'b0;
      left_hold   = '0;
      right_hold  = '0;
      cfg         = '{goal_tol: 23'd205, lookahead: 23'd819, speed_gain: 16'd256,
                      turn_gain: 16'd256, drive_limit: 15'd32767};
      drive_results_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GOAL_TOL:  cfg.goal_tol    = cfg_data;
          REG_LOOKAHEAD: cfg.lookahead   = cfg_data;
          REG_SPEED:     cfg.speed_gain  = cfg_data[15:0];
          REG_TURN:      cfg.turn_gain   = cfg_data[15:0];
          REG_LIMIT:     cfg.drive_limit = cfg_data[14:0];
          default: ;
        endcase
      end
      if (out_pop && !out_empty) begin
        if (drive_results_q.size() == 0) begin
          $error("result request arrived with no prediction waiting");
          fail_count++;
        end else begin
          want = drive_results_q.pop_front();
          if (out_item.left_drive !== want.left_drive) begin
            $error("left_drive: expected %0d, got %0d", want.left_drive, out_item.left_drive);
            fail_count++;
          end
          if (out_item.right_drive !== want.right_drive) begin
            $error("right_drive: expected %0d, got %0d", want.right_drive,
                   out_item.right_drive);
            fail_count++;
          end
          if (out_item.tracking !== want.tracking) begin
            $error("tracking: expected %0d, got %0d", want.tracking, out_item.tracking);
            fail_count++;
          end
          if (out_item.event_res !== want.event_res) begin
            $error("event_res: expected %0d, got %0d", want.event_res, out_item.event_res);
            fail_count++;
          end
          if (out_item.target_index !== want.target_index) begin
            $error("target_index: expected %0d, got %0d", want.target_index,
                   out_item.target_index);
            fail_count++;
          end
        end
      end
      if (in_push && !in_full) drive_results_q.push_back(predict_result(in_item));
    end
    pending = drive_results_q.size();
  end

  initial begin
    fail_count = 0;
    pending    = 0;
  end

endmodule

[tb/tb_waypoint_tracking_drive_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_waypoint_tracking_drive_top: testbench of the waypoint tracking drive
// Drives directed and random load, start and pose requests through several
// register settings and idling patterns; a checker module predicts and
// compares every result, and this module gives the verdict.
// ============================================================================
module tb_waypoint_tracking_drive_top;
  import wtd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  wtd_in_t     in_item;
  logic        out_empty;
  logic        out_pop;
  wtd_out_t    out_item;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [22:0] cfg_data;
  int          fail_count;
  int          pending;

  int          send_idle_pct;
  int          recv_stall_pct;
  logic        hold_go;
  int          quiet_cycles;
  int          sent_count;

  // Waypoints as the stimulus believes them to be loaded.
  logic signed [23:0] route_x[$];
  logic signed [23:0] route_y[$];

  waypoint_tracking_drive_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  wtd_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        out_pop = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_pop = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles in which neither side moves a request.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offers one request; entered and left at a falling edge.
  task automatic send_request(logic [1:0] cmd, logic np, logic signed [23:0] x,
                              logic signed [23:0] y, logic signed [15:0] hd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push = 1'b1;
    in_item = '{command: cmd, new_path: np, coord_x: x, coord_y: y, heading: hd};
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
    sent_count++;
    if (cmd == CMD_LOAD) begin
      if (np) begin
        route_x.delete();
        route_y.delete();
      end
      if (route_x.size() < 256) begin
        route_x.push_back(x);
        route_y.push_back(y);
      end
    end
  endtask

  // Waits until every result has come, then idles before returning.
  task automatic wait_idle();
    in_push = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [22:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_regs(logic [22:0] tol, logic [22:0] look, logic [15:0] spd,
                          logic [15:0] trn, logic [14:0] lim);
    write_reg(REG_GOAL_TOL, tol);
    write_reg(REG_LOOKAHEAD, look);
    write_reg(REG_SPEED, 23'(spd));
    write_reg(REG_TURN, 23'(trn));
    write_reg(REG_LIMIT, 23'(lim));
  endtask

  function automatic logic signed [23:0] near_coord(logic signed [23:0] c, int span);
    return c + 24'($signed($urandom_range(2 * span)) - span);
  endfunction

  // Random requests, mostly well-formed paths followed by pose steps near them.
  task automatic random_requests(int count);
    int                 pick, n, k;
    logic signed [23:0] bx, by;
    for (int it = 0; it < count; it++) begin
      pick = $urandom_range(99);
      if (pick < 6 || route_x.size() == 0) begin
        n  = $urandom_range(1, 6);
        bx = 24'($signed($urandom_range(81920)) - 40960);
        by = 24'($signed($urandom_range(81920)) - 40960);
        for (int p = 0; p < n; p++) begin
          send_request(CMD_LOAD, p == 0, bx, by, 16'($urandom));
          bx = near_coord(bx, 8192);
          by = near_coord(by, 8192);
        end
        send_request(CMD_START, 1'($urandom), 24'($urandom), 24'($urandom), 16'($urandom));
      end else if (pick < 9) begin
        send_request(CMD_LOAD, $urandom_range(3) == 0, near_coord(route_x[$], 8192),
                     near_coord(route_y[$], 8192), 16'($urandom));
      end else if (pick < 11) begin
        send_request(CMD_START, 1'($urandom), 24'($urandom), 24'($urandom), 16'($urandom));
      end else if (pick < 12) begin
        send_request(2'd3, 1'($urandom), 24'($urandom), 24'($urandom), 16'($urandom));
      end else if (pick < 15) begin
        send_request(2'($urandom_range(2)), 1'($urandom), 24'($urandom), 24'($urandom),
                     16'($urandom));
      end else begin
        k = $urandom_range(route_x.size() - 1);
        if ($urandom_range(3) == 0) k = route_x.size() - 1;
        n = ($urandom_range(2) == 0) ? 300 : 4096;
        send_request(CMD_POSE, 1'($urandom), near_coord(route_x[k], n),
                     near_coord(route_y[k], n),
                     ($urandom_range(1) == 0) ? 16'($urandom) :
                                                16'($signed($urandom_range(8000)) - 4000));
      end
    end
  endtask

  initial begin
    in_push        = 1'b0;
    in_item        = '0;
    cfg_we         = 1'b0;
    cfg_index      = REG_GOAL_TOL;
    cfg_data       = '0;
    hold_go        = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    quiet_cycles   = 0;
    sent_count     = 0;
    rst_n          = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: error and ignore cases, extreme coordinates, each event.
    send_request(CMD_START, 1'b0, '0, '0, '0);
    send_request(CMD_POSE, 1'b1, 24'sh800000, 24'sh7fffff, 16'sh8000);
    send_request(2'd3, 1'b1, 24'shffffff, 24'shffffff, 16'shffff);
    send_request(CMD_LOAD, 1'b1, 24'sh7fffff, 24'sh800000, '0);
    send_request(CMD_LOAD, 1'b0, 24'sh800000, 24'sh7fffff, '0);
    send_request(CMD_POSE, 1'b0, '0, '0, 16'sh7fff);
    send_request(CMD_START, 1'b0, '0, '0, '0);
    send_request(CMD_POSE, 1'b0, 24'sh800000, 24'sh7fffff, 16'sh7fff);
    send_request(CMD_POSE, 1'b0, 24'sh7fff00, 24'sh800000, 16'sh8000);
    send_request(CMD_POSE, 1'b0, 24'sh800100, 24'sh7fffff, '0);
    send_request(CMD_POSE, 1'b0, 24'sh800000, 24'sh7fffff, '0);
    send_request(CMD_LOAD, 1'b1, 24'sd0, 24'sd0, '0);
    send_request(CMD_LOAD, 1'b0, 24'sd8192, 24'sd0, '0);
    send_request(CMD_START, 1'b0, '0, '0, '0);
    send_request(CMD_POSE, 1'b0, -24'sd4000, -24'sd3000, 16'sd1000);
    send_request(CMD_POSE, 1'b0, 24'sd4000, -24'sd3000, -16'sd1000);
    send_request(CMD_LOAD, 1'b0, 24'sd12000, 24'sd5000, '0);
    send_request(CMD_LOAD, 1'b1, 24'sd100, 24'sd100, '0);
    send_request(CMD_POSE, 1'b0, 24'sd50, 24'sd90, '0);
    send_request(CMD_POSE, 1'b0, 24'sd9000, 24'sd9000, '0);

    // Phases of register settings and idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      case (ph)
        1: set_regs(23'h7fffff, 23'h7fffff, 16'hffff, 16'hffff, 15'h7fff);
        2: set_regs(23'd0, 23'd0, 16'd0, 16'd0, 15'd0);
        3: set_regs(23'd100, 23'd1500, 16'hffff, 16'd0, 15'd20000);
        4: set_regs(23'd0, 23'd0, 16'd0, 16'hffff, 15'd1);
        5, 6, 7: set_regs(23'($urandom_range(3000)), 23'($urandom_range(200, 10000)),
                          16'($urandom), 16'($urandom), 15'($urandom));
        default: ;
      endcase
      send_idle_pct  = (ph % 4 == 1) ? 82 : (ph % 4 == 3) ? 21 : 0;
      recv_stall_pct = (ph % 4 == 2) ? 82 : (ph % 4 == 3) ? 21 : 0;
      if (ph == 1) hold_go = 1'b1;
      // Overflow the path store once, then start tracking on it.
      if (ph == 5) begin
        for (int p = 0; p < 258; p++)
          send_request(CMD_LOAD, p == 0, 24'(p * 512), 24'($urandom_range(4096)), '0);
        send_request(CMD_START, 1'b0, '0, '0, '0);
      end
      random_requests(50);
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hdl/wtd_pkg.sv
hdl/wtd_front.sv
hdl/wtd_exec.sv
hdl/waypoint_tracking_drive_top.sv
tb/wtd_checker.sv
tb/tb_waypoint_tracking_drive_top.sv
